// File: rtl/pulse_count_code_lock_top_defines.svh
// Assertion macros used by the code lock top level.
`ifndef PULSE_COUNT_CODE_LOCK_TOP_DEFINES_SVH
`define PULSE_COUNT_CODE_LOCK_TOP_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define PLC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger implies a condition on the same clock edge.
`define PLC_ASSERT_IMPL(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

`endif

// File: rtl/plc_pkg.sv
// Shared types, constants and functions of the code lock.
package plc_pkg;

    // Phase codes.
    localparam logic [2:0] PH_WAIT_FIRST  = 3'd0;
    localparam logic [2:0] PH_WAIT_SECOND = 3'd1;
    localparam logic [2:0] PH_CHECK       = 3'd2;
    localparam logic [2:0] PH_CORRECT     = 3'd3;
    localparam logic [2:0] PH_WRONG       = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_CODE_FIRST    = 2'd0;
    localparam logic [1:0] REG_CODE_SECOND   = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE      = 2'd2;
    localparam logic [1:0] REG_DIGIT_TIMEOUT = 2'd3;

    // Register values after reset.
    localparam logic [3:0]  RST_CODE_FIRST    = 4'd2;
    localparam logic [3:0]  RST_CODE_SECOND   = 4'd3;
    localparam logic [7:0]  RST_DEBOUNCE      = 8'd5;
    localparam logic [15:0] RST_DIGIT_TIMEOUT = 16'd100;

    // Count limit and idle timer saturation value.
    localparam logic [2:0]  COUNT_MAX = 3'd4;
    localparam logic [15:0] IDLE_MAX  = 16'hFFFF;

    // Configuration seen by the core.
    typedef struct packed {
        logic [3:0]  code_first;
        logic [3:0]  code_second;
        logic [7:0]  holdoff_ticks;
        logic [15:0] digit_timeout_ticks;
    } plc_cfg_t;

    // One result item.
    typedef struct packed {
        logic [6:0] segment_pattern;
        logic       unlock_event;
        logic       wrong_code_event;
        logic       alarm_event;
        logic [2:0] phase_now;
    } plc_result_t;

    // Seven-segment pattern for a count of 0 to 4; bit0 is segment A.
    function automatic logic [6:0] seg_of_count(input logic [2:0] count);
        logic [6:0] pat;
        case (count)
            3'd1:    pat = 7'b0000110;
            3'd2:    pat = 7'b1011011;
            3'd3:    pat = 7'b1001111;
            3'd4:    pat = 7'b1100110;
            default: pat = 7'b0000000;
        endcase
        return pat;
    endfunction

endpackage

// File: rtl/plc_core.sv
// Lock state and the per-item update of counts, timers, phase and display.
module plc_core
    import plc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        sensor_one_active,
    input  logic        sensor_two_active,
    input  logic        emergency_press,
    input  plc_cfg_t    cfg,
    output plc_result_t result
);

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  count_first_reg, count_first_next;
    logic [2:0]  count_second_reg, count_second_next;
    logic [15:0] idle_first_reg, idle_first_next;
    logic [15:0] idle_second_reg, idle_second_next;
    logic [7:0]  holdoff_first_reg, holdoff_first_next;
    logic [7:0]  holdoff_second_reg, holdoff_second_next;
    logic        last_first_reg, last_first_next;
    logic        last_second_reg, last_second_next;
    logic [6:0]  shown_reg, shown_next;
    logic        unlock_next, wrong_next, alarm_next;

    // Next state for one item.
    always_comb
    begin
        phase_next          = phase_reg;
        count_first_next    = count_first_reg;
        count_second_next   = count_second_reg;
        idle_first_next     = idle_first_reg;
        idle_second_next    = idle_second_reg;
        holdoff_first_next  = holdoff_first_reg;
        holdoff_second_next = holdoff_second_reg;
        last_first_next     = last_first_reg;
        last_second_next    = last_second_reg;
        shown_next          = shown_reg;
        unlock_next         = 1'b0;
        wrong_next          = 1'b0;
        alarm_next          = 1'b0;

        if (emergency_press)
        begin
            phase_next          = PH_WAIT_FIRST;
            count_first_next    = '0;
            count_second_next   = '0;
            idle_first_next     = '0;
            idle_second_next    = '0;
            holdoff_first_next  = '0;
            holdoff_second_next = '0;
            last_first_next     = 1'b0;
            last_second_next    = 1'b0;
            shown_next          = '0;
            alarm_next          = 1'b1;
        end
        else
        begin
            // Debounce holdoffs count down toward zero.
            if (holdoff_first_reg != 8'd0)
                holdoff_first_next = holdoff_first_reg - 8'd1;
            if (holdoff_second_reg != 8'd0)
                holdoff_second_next = holdoff_second_reg - 8'd1;

            // First digit: edge counting and idle timer.
            if (phase_reg == PH_WAIT_FIRST)
            begin
                if (sensor_one_active && !last_first_reg && holdoff_first_next == 8'd0)
                begin
                    if (count_first_reg < COUNT_MAX)
                    begin
                        count_first_next = count_first_reg + 3'd1;
                        shown_next = seg_of_count(count_first_next);
                    end
                    idle_first_next    = '0;
                    holdoff_first_next = cfg.holdoff_ticks;
                end
                if (count_first_next != 3'd0 && idle_first_next != IDLE_MAX)
                    idle_first_next = idle_first_next + 16'd1;
            end

            // Second digit: edge counting and idle timer.
            if (phase_reg == PH_WAIT_SECOND)
            begin
                if (sensor_two_active && !last_second_reg && holdoff_second_next == 8'd0)
                begin
                    if (count_second_reg < COUNT_MAX)
                    begin
                        count_second_next = count_second_reg + 3'd1;
                        shown_next = seg_of_count(count_second_next);
                    end
                    idle_second_next    = '0;
                    holdoff_second_next = cfg.holdoff_ticks;
                end
                if (count_second_next != 3'd0 && idle_second_next != IDLE_MAX)
                    idle_second_next = idle_second_next + 16'd1;
            end

            last_first_next  = sensor_one_active;
            last_second_next = sensor_two_active;

            // Phase sequencing.
            case (phase_reg)
                PH_WAIT_FIRST:
                begin
                    if (count_first_next != 3'd0 &&
                        idle_first_next >= cfg.digit_timeout_ticks)
                    begin
                        phase_next       = PH_WAIT_SECOND;
                        idle_second_next = '0;
                    end
                end
                PH_WAIT_SECOND:
                begin
                    if (count_second_next != 3'd0 &&
                        idle_second_next >= cfg.digit_timeout_ticks)
                        phase_next = PH_CHECK;
                end
                PH_CHECK:
                begin
                    if ({1'b0, count_first_next} == cfg.code_first &&
                        {1'b0, count_second_next} == cfg.code_second)
                        phase_next = PH_CORRECT;
                    else
                        phase_next = PH_WRONG;
                end
                default:
                begin
                    // Correct, wrong and unused codes all return to the start.
                    unlock_next         = (phase_reg == PH_CORRECT);
                    wrong_next          = (phase_reg == PH_WRONG);
                    phase_next          = PH_WAIT_FIRST;
                    count_first_next    = '0;
                    count_second_next   = '0;
                    idle_first_next     = '0;
                    idle_second_next    = '0;
                    holdoff_first_next  = '0;
                    holdoff_second_next = '0;
                    last_first_next     = 1'b0;
                    last_second_next    = 1'b0;
                    shown_next          = '0;
                end
            endcase
        end
    end

    // State registers, updated once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_WAIT_FIRST;
            count_first_reg    <= '0;
            count_second_reg   <= '0;
            idle_first_reg     <= '0;
            idle_second_reg    <= '0;
            holdoff_first_reg  <= '0;
            holdoff_second_reg <= '0;
            last_first_reg     <= 1'b0;
            last_second_reg    <= 1'b0;
            shown_reg          <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            count_first_reg    <= count_first_next;
            count_second_reg   <= count_second_next;
            idle_first_reg     <= idle_first_next;
            idle_second_reg    <= idle_second_next;
            holdoff_first_reg  <= holdoff_first_next;
            holdoff_second_reg <= holdoff_second_next;
            last_first_reg     <= last_first_next;
            last_second_reg    <= last_second_next;
            shown_reg          <= shown_next;
        end
    end

    // The result item reflects the state after this item.
    assign result.segment_pattern  = shown_next;
    assign result.unlock_event     = unlock_next;
    assign result.wrong_code_event = wrong_next;
    assign result.alarm_event      = alarm_next;
    assign result.phase_now        = phase_next;

endmodule

// File: rtl/pulse_count_code_lock_top.sv
// Top level of the two-digit pulse count code lock.
// Each accepted input item is one tick and yields exactly one result item,
// which passes through the input register and then the output register. A new
// item is taken in every cycle while the output is not stalled: the item sits in
// an input register, the lock state is updated in a single pass of logic, and
// the result lands in an output register, so the sustained rate is one item
// per cycle while the output is not stalled. Configuration writes complete
// in the cycle they are offered.
`include "pulse_count_code_lock_top_defines.svh"

module pulse_count_code_lock_top
    import plc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        sensor_one_active,
    input  logic        sensor_two_active,
    input  logic        emergency_press,
    // Result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  segment_pattern,
    output logic        unlock_event,
    output logic        wrong_code_event,
    output logic        alarm_event,
    output logic [2:0]  phase_now,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    plc_cfg_t    cfg_reg;
    plc_result_t result;
    plc_result_t res_reg;
    logic        in_valid_reg;
    logic        out_valid_reg;
    logic        s1_reg, s2_reg, emg_reg;
    logic        out_free;
    logic        step;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_first          <= RST_CODE_FIRST;
            cfg_reg.code_second         <= RST_CODE_SECOND;
            cfg_reg.holdoff_ticks       <= RST_DEBOUNCE;
            cfg_reg.digit_timeout_ticks <= RST_DIGIT_TIMEOUT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CODE_FIRST:    cfg_reg.code_first          <= cfg_data[3:0];
                REG_CODE_SECOND:   cfg_reg.code_second         <= cfg_data[3:0];
                REG_DEBOUNCE:      cfg_reg.holdoff_ticks       <= cfg_data[7:0];
                REG_DIGIT_TIMEOUT: cfg_reg.digit_timeout_ticks <= cfg_data[15:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Pipeline flow: the output register frees when its item is taken.
    assign out_free = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_reg  <= sensor_one_active;
            s2_reg  <= sensor_two_active;
            emg_reg <= emergency_press;
        end
    end

    plc_core u_core
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .sensor_one_active (s1_reg),
        .sensor_two_active (s2_reg),
        .emergency_press   (emg_reg),
        .cfg               (cfg_reg),
        .result            (result)
    );

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= step;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= result;
    end

    assign out_valid        = out_valid_reg;
    assign segment_pattern  = res_reg.segment_pattern;
    assign unlock_event     = res_reg.unlock_event;
    assign wrong_code_event = res_reg.wrong_code_event;
    assign alarm_event      = res_reg.alarm_event;
    assign phase_now        = res_reg.phase_now;

    // At most one event is given per item.
    `PLC_ASSERT_ALWAYS(a_one_event, !out_valid || $onehot0({unlock_event, wrong_code_event, alarm_event}), "more than one event in an item")
    // An alarm leaves the lock at the start with a blank display.
    `PLC_ASSERT_IMPL(a_alarm_clears, out_valid && alarm_event, phase_now == PH_WAIT_FIRST && segment_pattern == 7'd0, "alarm did not clear the lock")
    // A verdict event always returns the lock to the start.
    `PLC_ASSERT_IMPL(a_verdict_clears, out_valid && (unlock_event || wrong_code_event), phase_now == PH_WAIT_FIRST && segment_pattern == 7'd0, "verdict did not clear the lock")
    // A stalled result is not overwritten by a new item.
    `PLC_ASSERT_IMPL(a_no_overrun, out_valid_reg && !out_ready, !step, "result register overwritten while stalled")

endmodule
